// ===== rtl/multichannel_pulse_width_capture_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the pulse width capture unit
// Shared property shorthands, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_PULSE_WIDTH_CAPTURE_UNIT_DEFINES_SVH
`define MULTICHANNEL_PULSE_WIDTH_CAPTURE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MPWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpwc_pkg.sv =====
// ---------------------------------------------------------------------------
// mpwc_pkg
// Types and constants shared by the pulse width capture unit.
// ---------------------------------------------------------------------------
package mpwc_pkg;

  localparam int CHANNELS  = 6;
  localparam int CH_W      = 3;
  localparam int WIDTH_W   = 16;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 1'd1;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd800;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2200;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] channel;
    logic            pin_level;
  } evt_req_t;

  typedef struct packed {
    logic [CH_W-1:0]    out_channel;
    logic               level_now;
    logic [WIDTH_W-1:0] pulse_width_us;
    logic               width_fresh;
    logic               accepted_now;
    logic [CNT_W-1:0]   edges_seen;
    logic [CNT_W-1:0]   rises_seen;
    logic [CNT_W-1:0]   falls_seen;
  } res_req_t;

  // Per-channel state held in the channel store.
  typedef struct packed {
    logic [TIME_W-1:0]  rise_stamp;
    logic [WIDTH_W-1:0] last_width;
    logic               fresh_flag;
    logic               chan_level;
    logic [CNT_W-1:0]   edge_total;
    logic [CNT_W-1:0]   rise_total;
    logic [CNT_W-1:0]   fall_total;
  } chan_entry_t;

endpackage

// ===== rtl/mpwc_chan_store.sv =====
// ---------------------------------------------------------------------------
// mpwc_chan_store
// Per-channel state memory with a registered read, reset-valid bits
// and a bypass of the write that lands on the same edge as a read.
// ---------------------------------------------------------------------------
module mpwc_chan_store
  import mpwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CH_W-1:0]   rd_addr,
  output chan_entry_t       rd_entry,
  input  logic              wr_en,
  input  logic [CH_W-1:0]   wr_addr,
  input  chan_entry_t       wr_data
);

  chan_entry_t         mem [CHANNELS];
  chan_entry_t         rd_q;
  logic [CH_W-1:0]     addr_q;
  logic [CHANNELS-1:0] vld;
  logic                wb_valid;
  logic [CH_W-1:0]     wb_addr;
  chan_entry_t         wb_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      addr_q <= rd_addr;
    end
  end

  // The last write is kept so a read issued on the same edge still sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      wb_valid <= 1'b0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
      wb_valid     <= 1'b1;
    end
    if (wr_en) begin
      wb_addr <= wr_addr;
      wb_data <= wr_data;
    end
  end

  always_comb begin
    if (wb_valid && (wb_addr == addr_q)) begin
      rd_entry = wb_data;
    end else if (vld[addr_q]) begin
      rd_entry = rd_q;
    end else begin
      rd_entry = '0;
    end
  end

endmodule

// ===== rtl/multichannel_pulse_width_capture_unit.sv =====
// ---------------------------------------------------------------------------
// multichannel_pulse_width_capture_unit
// Measures the high-pulse width of several RC receiver channels from tick
// and edge requests, keeping per-channel counters and the last valid width.
// ---------------------------------------------------------------------------
// The unit takes one request per clock while evt_stall is low. A tick
// advances the 32-bit microsecond timer; an edge on a channel in range
// produces one result, through the channel store read into the update
// stage and then the update into the result register. Ticks and edges on
// channels outside the range give no result. Back-to-back edges on the same
// channel are handled by a bypass around the store, so the rate stays at one
// request per cycle while results are taken. Window registers may only be
// written while no edge is in flight.
`include "multichannel_pulse_width_capture_unit_defines.svh"

module multichannel_pulse_width_capture_unit
  import mpwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 evt_valid,
  output logic                 evt_stall,
  input  evt_req_t             evt,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_req_t             res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  logic [WIDTH_W-1:0] min_width_us;
  logic [WIDTH_W-1:0] max_width_us;
  logic [TIME_W-1:0]  time_us;

  logic               evt_acc;
  logic               s1_load;
  logic               s1_go;
  logic               s1_valid;
  logic [CH_W-1:0]    s1_ch;
  logic               s1_lvl;
  logic [TIME_W-1:0]  s1_time;

  chan_entry_t        cur_entry;
  chan_entry_t        new_entry;
  logic [TIME_W-1:0]  width;
  logic               in_window;
  logic               accepted;
  res_req_t           res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width_us <= MIN_WIDTH_RESET;
      max_width_us <= MAX_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_WIDTH: min_width_us <= cfg_data;
        REG_MAX_WIDTH: max_width_us <= cfg_data;
        default: ;
      endcase
    end
  end

  assign evt_stall = s1_valid && !s1_go;
  assign evt_acc   = evt_valid && !evt_stall;
  assign s1_load   = evt_acc && (evt.cmd == CMD_EDGE) &&
                     ({1'b0, evt.channel} < (CH_W+1)'(CHANNELS));
  assign s1_go     = s1_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_us <= '0;
    end else if (evt_acc && (evt.cmd == CMD_TICK)) begin
      time_us <= time_us + 1'b1;
    end
  end

  // The edge is stamped with the timer value before this request.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
    if (s1_load) begin
      s1_ch   <= evt.channel;
      s1_lvl  <= evt.pin_level;
      s1_time <= time_us;
    end
  end

  mpwc_chan_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (s1_load),
    .rd_addr  (evt.channel),
    .rd_entry (cur_entry),
    .wr_en    (s1_go),
    .wr_addr  (s1_ch),
    .wr_data  (new_entry)
  );

  always_comb begin
    width     = s1_time - cur_entry.rise_stamp;
    in_window = (width >= {16'b0, min_width_us}) && (width <= {16'b0, max_width_us});
    accepted  = !s1_lvl && in_window;

    new_entry            = cur_entry;
    new_entry.edge_total = cur_entry.edge_total + 1'b1;
    new_entry.chan_level = s1_lvl;
    if (s1_lvl) begin
      new_entry.rise_total = cur_entry.rise_total + 1'b1;
      new_entry.rise_stamp = s1_time;
    end else begin
      new_entry.fall_total = cur_entry.fall_total + 1'b1;
      if (in_window) begin
        new_entry.last_width = width[WIDTH_W-1:0];
        new_entry.fresh_flag = 1'b1;
      end
    end

    res_next.out_channel    = s1_ch;
    res_next.level_now      = new_entry.chan_level;
    res_next.pulse_width_us = new_entry.last_width;
    res_next.width_fresh    = new_entry.fresh_flag;
    res_next.accepted_now   = accepted;
    res_next.edges_seen     = new_entry.edge_total;
    res_next.rises_seen     = new_entry.rise_total;
    res_next.falls_seen     = new_entry.fall_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (s1_go) begin
      res <= res_next;
    end
  end

  `MPWC_ASSERT_NOW(a_stall_only_when_busy, evt_stall, s1_valid && res_valid && res_stall, "input stalled while the update stage could move")
  `MPWC_ASSERT_NEXT(a_edge_enters_stage, s1_load, s1_valid, "accepted edge did not reach the update stage")
  `MPWC_ASSERT_NEXT(a_tick_advances, evt_acc && (evt.cmd == CMD_TICK), time_us == $past(time_us) + 1'b1, "timer did not advance on a tick")
  `MPWC_ASSERT_NOW(a_accept_on_fall, res_valid && res.accepted_now, !res.level_now && res.width_fresh, "accepted width reported without a fall or fresh flag")

endmodule

// ===== tb/multichannel_pulse_width_capture_unit_tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for multichannel_pulse_width_capture_unit
// Drives tick and edge requests with random gaps and receiver stalls, predicts
// every edge result with a cycle-free model of the channel state, and compares
// the results field by field across several pulse-width windows.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module multichannel_pulse_width_capture_unit_tb
  import mpwc_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 4;

  // Tracks the channel state and the window, and holds the results still owed.
  class width_capture_sb;
    logic [WIDTH_W-1:0] win_lo;
    logic [WIDTH_W-1:0] win_hi;
    logic [TIME_W-1:0]  clock_us;
    logic [TIME_W-1:0]  stamp_us   [CHANNELS];
    logic [WIDTH_W-1:0] width_kept [CHANNELS];
    logic               fresh      [CHANNELS];
    logic               level      [CHANNELS];
    logic [CNT_W-1:0]   n_edges    [CHANNELS];
    logic [CNT_W-1:0]   n_rises    [CHANNELS];
    logic [CNT_W-1:0]   n_falls    [CHANNELS];
    res_req_t           pending_results[$];
    int                 mismatches;
    int                 checked;

    function new();
      win_lo = MIN_WIDTH_RESET;
      win_hi = MAX_WIDTH_RESET;
      clock_us = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        stamp_us[c]   = '0;
        width_kept[c] = '0;
        fresh[c]      = 1'b0;
        level[c]      = 1'b0;
        n_edges[c]    = '0;
        n_rises[c]    = '0;
        n_falls[c]    = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    function void note_request(evt_req_t r);
      logic [TIME_W-1:0] span;
      res_req_t          e;
      int                c;
      if (r.cmd == CMD_TICK) begin
        clock_us = clock_us + 1;
        return;
      end
      if (r.channel >= CHANNELS) return;
      c = int'(r.channel);
      e.accepted_now = 1'b0;
      n_edges[c] = n_edges[c] + 1;
      level[c] = r.pin_level;
      if (r.pin_level) begin
        n_rises[c] = n_rises[c] + 1;
        stamp_us[c] = clock_us;
      end else begin
        n_falls[c] = n_falls[c] + 1;
        span = clock_us - stamp_us[c];
        if (span >= {16'b0, win_lo} && span <= {16'b0, win_hi}) begin
          width_kept[c] = span[WIDTH_W-1:0];
          fresh[c] = 1'b1;
          e.accepted_now = 1'b1;
        end
      end
      e.out_channel    = r.channel;
      e.level_now      = level[c];
      e.pulse_width_us = width_kept[c];
      e.width_fresh    = fresh[c];
      e.edges_seen     = n_edges[c];
      e.rises_seen     = n_rises[c];
      e.falls_seen     = n_falls[c];
      pending_results.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                  checked, name, got, want));
    endtask

    task check_result(res_req_t got);
      res_req_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result on channel %0d with nothing expected",
                                  got.out_channel));
        return;
      end
      want = pending_results.pop_front();
      compare_field("out_channel", 32'(got.out_channel), 32'(want.out_channel));
      compare_field("level_now", 32'(got.level_now), 32'(want.level_now));
      compare_field("pulse_width_us", 32'(got.pulse_width_us),
                    32'(want.pulse_width_us));
      compare_field("width_fresh", 32'(got.width_fresh), 32'(want.width_fresh));
      compare_field("accepted_now", 32'(got.accepted_now), 32'(want.accepted_now));
      compare_field("edges_seen", got.edges_seen, want.edges_seen);
      compare_field("rises_seen", got.rises_seen, want.rises_seen);
      compare_field("falls_seen", got.falls_seen, want.falls_seen);
      checked++;
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_stall;
  evt_req_t             evt = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_req_t             res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WIDTH_W-1:0]   cfg_data = '0;

  width_capture_sb sb;
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;
  logic            lvl_track [8];
  int              quiet_cycles = 0;
  int              sent = 0;
  int              ticks_sent = 0;
  int              windows = 0;

  multichannel_pulse_width_capture_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Handshake monitor, scoreboard feed and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (evt_valid && !evt_stall) sb.note_request(evt);
      if (res_valid && !res_stall) sb.check_result(res);
      if ((evt_valid && !evt_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("[multichannel_pulse_width_capture_unit] ERROR");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on demand.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input evt_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    evt_valid <= 1'b1;
    evt <= r;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    sent++;
    if (r.cmd == CMD_TICK) ticks_sent++;
    else lvl_track[r.channel] = r.pin_level;
  endtask

  task automatic send_edge(input int ch, input logic lvl);
    evt_req_t r;
    r.cmd = CMD_EDGE;
    r.channel = ch[CH_W-1:0];
    r.pin_level = lvl;
    send_request(r);
  endtask

  // Tick requests carry random channel and level bits, which must be ignored.
  task automatic send_ticks(input int n);
    evt_req_t r;
    for (int i = 0; i < n; i++) begin
      r.cmd = CMD_TICK;
      r.channel = CH_W'($urandom_range(0, 7));
      r.pin_level = 1'($urandom_range(0, 1));
      send_request(r);
    end
  endtask

  // Mostly ticks and alternating edges so that pulses form on every channel,
  // with some raw edges that repeat a level or name a channel out of range.
  task automatic run_random(input int n);
    evt_req_t r;
    int       roll;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      r.cmd = CMD_TICK;
      r.channel = CH_W'($urandom_range(0, 7));
      r.pin_level = 1'($urandom_range(0, 1));
      if (roll >= 45 && roll < 90) begin
        r.cmd = CMD_EDGE;
        r.channel = CH_W'($urandom_range(0, CHANNELS - 1));
        r.pin_level = !lvl_track[r.channel];
      end else if (roll >= 90) begin
        r.cmd = CMD_EDGE;
      end
      send_request(r);
    end
  endtask

  // Waits until every edge result is back and any trailing tick has settled.
  task automatic settle();
    evt_valid <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_WIDTH;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_WIDTH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.win_lo = lo;
    sb.win_hi = hi;
    windows++;
  endtask

  initial begin
    sb = new();
    for (int c = 0; c < 8; c++) lvl_track[c] = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Out-of-range channels, repeated levels, a fall with no rise and short
    // pulses that the reset window of 800 to 2200 us turns away.
    send_edge(7, 1'b1);
    send_edge(6, 1'b0);
    send_ticks(1);
    send_edge(0, 1'b0);
    send_edge(0, 1'b0);
    send_edge(1, 1'b1);
    send_ticks(20);
    send_edge(1, 1'b0);
    send_edge(5, 1'b1);
    send_edge(5, 1'b1);
    send_ticks(3);
    send_edge(5, 1'b0);
    send_edge(5, 1'b0);
    settle();

    // Both window bounds are inclusive.
    set_window(16'd3, 16'd6);
    send_edge(2, 1'b1);
    send_ticks(2);
    send_edge(2, 1'b0);
    send_edge(3, 1'b1);
    send_ticks(3);
    send_edge(3, 1'b0);
    send_edge(4, 1'b1);
    send_ticks(6);
    send_edge(4, 1'b0);
    send_edge(0, 1'b1);
    send_ticks(7);
    send_edge(0, 1'b0);
    settle();

    set_window(16'd0, 16'hFFFF);
    run_random(150);
    settle();

    // A zero-width window only takes a fall right after its rise.
    set_window(16'd0, 16'd0);
    run_random(100);
    settle();

    // The long hold-off lets the unit fill up and stall its input.
    set_window(16'd5, 16'd12);
    run_random(60);
    hold_req = 1'b1;
    run_random(140);
    settle();

    set_window(16'd20, 16'd10);
    run_random(100);
    settle();

    set_window(16'hFFFF, 16'hFFFF);
    run_random(50);
    settle();

    idle_on = 1'b0;
    set_window(16'd1, 16'd8);
    run_random(150);
    settle();

    $display("Run covered %0d requests (%0d ticks) and %0d edge results over %0d windows,",
             sent, ticks_sent, sb.checked, windows + 1);
    $display("including empty, zero-width, inverted and full windows and a long result hold-off.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[multichannel_pulse_width_capture_unit] OK");
    end else begin
      $display("[multichannel_pulse_width_capture_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mpwc_pkg.sv
rtl/mpwc_chan_store.sv
rtl/multichannel_pulse_width_capture_unit.sv
tb/multichannel_pulse_width_capture_unit_tb.sv
